// ===== rtl/core/cfd_pkg.sv =====
// Shared types, constants and the CRC-16 byte step for the frame deframer.
`timescale 1ns / 1ps
package cfd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned HDR_W      = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;

    // Frame layout: header (2), length, command, payload, CRC (2)
    localparam int unsigned BODY_OFFSET    = 4;
    localparam int unsigned FRAME_OVERHEAD = 6;

    localparam logic [HDR_W-1:0] HEADER_RESET = 16'hAA55;
    localparam logic [LEN_W-1:0] LIMIT_RESET  = 6'd32;
    localparam logic [15:0]      CRC_INIT     = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY     = 16'h1021;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        FR_MORE,
        FR_DROP,
        FR_READY
    } t_feed_res;

    // Controller to datapath
    typedef struct packed {
        logic feed_new;     // feed the byte on the input channel
        logic rd_replay;    // read the next stored byte for replay
        logic feed_replay;  // feed the stored byte read last cycle
        logic rd_emit;      // read the payload byte of the next result
        logic load_out;     // load the next result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic      replay_pending;
        logic      out_free;
        logic      last_item;
        t_feed_res feed_res;
    } t_sts;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/cfd_byte_if.sv =====
// Valid/ready channel carrying one received link byte.
`timescale 1ns / 1ps
interface cfd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [cfd_pkg::BYTE_W-1:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/cfd_result_if.sv =====
// Valid/ready channel carrying one deframed result.
`timescale 1ns / 1ps
interface cfd_result_if;
    logic                       valid;
    logic                       ready;
    logic [cfd_pkg::BYTE_W-1:0] command;
    logic [cfd_pkg::LEN_W-1:0]  payload_length;
    logic [cfd_pkg::IDX_W-1:0]  byte_index;
    logic [cfd_pkg::BYTE_W-1:0] payload_byte;
    logic                       byte_present;
    logic                       last;

    modport source(output valid, output command, output payload_length, output byte_index,
                   output payload_byte, output byte_present, output last, input ready);
    modport sink(input valid, input command, input payload_length, input byte_index,
                 input payload_byte, input byte_present, input last, output ready);
endinterface

// ===== rtl/core/crc16_frame_deframer_unit.sv =====
// Top level of the header/length frame deframer with CRC-16/CCITT-FALSE check.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake     Carries
//  i_rx      in   valid/ready   rx_byte: one byte received from the link
//  o_res     out  valid/ready   command, payload_length, byte_index, payload_byte,
//                               byte_present, last: one result per payload byte (one if empty)
//  i_cfg_*   in   write enable  header_word (index 0), payload_limit (index 1)
//
//  A new byte is taken when no replay or emission is in progress.
//  A rejected frame (length above the limit or CRC mismatch) rewinds the byte
//  store and replays from the second header byte, each stored byte read
//  through the single RAM read port and then fed; input is held off meanwhile.
//  A good frame gives its results one at a time (RAM read, then output
//  register); emission halts while the output register is full and not taken.
//  Synchronous active-low reset; no clearing pass, the store is never read unwritten.
//
module crc16_frame_deframer_unit #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cfd_byte_if.sink                         i_rx,
    cfd_result_if.source                     o_res,
    input  logic                             i_cfg_we,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // Command and status between sequencer and datapath
    cfd_pkg::t_cmd cmd;
    cfd_pkg::t_sts sts;

    // Sequencer: decide each cycle whether to take a new request, replay a
    // stored byte or emit the next result
    cfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: hold the byte store, parse the frame, check CRC and drive the
    // output register
    cfd_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_rx_byte        (i_rx.rx_byte),
        .o_res_valid      (o_res.valid),
        .i_res_ready      (o_res.ready),
        .o_command        (o_res.command),
        .o_payload_length (o_res.payload_length),
        .o_byte_index     (o_res.byte_index),
        .o_payload_byte   (o_res.payload_byte),
        .o_byte_present   (o_res.byte_present),
        .o_last           (o_res.last)
    );

`ifndef SYNTHESIS
    // A frame found good must stop new requests in the following cycle
    a_ready_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.feed_new || cmd.feed_replay) && sts.feed_res == cfd_pkg::FR_READY
        |=> !i_rx.ready)
        else $error("input taken while a good frame awaits emission");

    // A result is only loaded into a free output register
    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> $past(sts.out_free))
        else $error("result loaded over a pending result");

    // An empty-frame result is always the last of its frame
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.byte_present |-> o_res.last)
        else $error("empty result not marked last");

    // A payload byte lies within its frame
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.byte_present |-> ({1'b0, o_res.byte_index} < o_res.payload_length))
        else $error("byte index beyond payload length");
`endif

endmodule

// ===== rtl/core/cfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cfd_dpath.sv =====
// Deframer datapath: byte store, replay pointers, frame parser, CRC and result register.
`timescale 1ns / 1ps
module cfd_dpath #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cfd_pkg::t_cmd                       i_cmd,
    output cfd_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [cfd_pkg::BYTE_W-1:0]          i_rx_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [cfd_pkg::BYTE_W-1:0]          o_command,
    output logic [cfd_pkg::LEN_W-1:0]           o_payload_length,
    output logic [cfd_pkg::IDX_W-1:0]           o_byte_index,
    output logic [cfd_pkg::BYTE_W-1:0]          o_payload_byte,
    output logic                                o_byte_present,
    output logic                                o_last
);

    localparam int unsigned STORE_DEPTH = MAX_PAYLOAD + cfd_pkg::FRAME_OVERHEAD;
    localparam int unsigned AW          = $clog2(STORE_DEPTH);
    localparam int unsigned RAM_DEPTH   = 2 ** AW;
    localparam int unsigned FW          = $clog2(STORE_DEPTH + 1);
    localparam int unsigned LW          = cfd_pkg::LEN_W;
    localparam int unsigned BW          = cfd_pkg::BYTE_W;

    typedef enum logic [2:0] {
        PH_HUNT_HI,
        PH_HUNT_LO,
        PH_LEN,
        PH_BODY,
        PH_CRC
    } t_phase;

    // Configuration
    logic [cfd_pkg::HDR_W-1:0] r_hdr;
    logic [LW-1:0]             r_limit;

    // Parser
    t_phase        r_phase, n_phase;
    logic [FW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_exp, n_exp;
    logic [15:0]   r_crc, n_crc;
    logic [BW-1:0] r_crc_hi, n_crc_hi;
    logic [BW-1:0] r_cmd_byte, n_cmd_byte;
    logic [AW-1:0] r_frm_ptr, n_frm_ptr;

    // Store pointers and emission counter
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_feed_pos;
    logic [LW-1:0] r_k;

    // Result register
    logic          r_out_valid;
    logic [BW-1:0] r_out_cmd;
    logic [LW-1:0] r_out_len;
    logic [cfd_pkg::IDX_W-1:0] r_out_idx;
    logic [BW-1:0] r_out_byte;
    logic          r_out_present;
    logic          r_out_last;

    logic [BW-1:0] ram_rdata;
    logic [AW-1:0] ram_raddr;

    logic                 feed_en;
    logic [BW-1:0]        feed_byte;
    logic [AW-1:0]        feed_pos;
    logic [BW-1:0]        hdr_hi;
    logic [BW-1:0]        hdr_lo;
    logic [LW-1:0]        limit_eff;
    logic                 hunt_like;
    logic                 take_first;
    logic [15:0]          crc_out;
    logic [FW-1:0]        fill_inc;
    logic [7:0]           fill_next8;
    logic [7:0]           exp8;
    cfd_pkg::t_feed_res   feed_res;
    logic                 exp_zero;
    logic                 item_last;

    assign feed_en   = i_cmd.feed_new | i_cmd.feed_replay;
    assign feed_byte = i_cmd.feed_replay ? ram_rdata : i_rx_byte;
    assign feed_pos  = i_cmd.feed_replay ? r_feed_pos : r_wr_ptr;
    assign hdr_hi    = r_hdr[15:8];
    assign hdr_lo    = r_hdr[7:0];
    assign limit_eff = (r_limit > LW'(MAX_PAYLOAD)) ? LW'(MAX_PAYLOAD) : r_limit;

    assign hunt_like = !(r_phase == PH_HUNT_LO || r_phase == PH_LEN ||
                         r_phase == PH_BODY || r_phase == PH_CRC);
    assign take_first = (hunt_like && feed_byte == hdr_hi) ||
                        (r_phase == PH_HUNT_LO && feed_byte != hdr_lo && feed_byte == hdr_hi);
    assign crc_out    = cfd_pkg::crc16_step(take_first ? cfd_pkg::CRC_INIT : r_crc, feed_byte);

    assign fill_inc   = r_fill + 1'b1;
    assign fill_next8 = 8'(fill_inc);
    assign exp8       = 8'(r_exp);

    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_exp      = r_exp;
        n_crc      = r_crc;
        n_crc_hi   = r_crc_hi;
        n_cmd_byte = r_cmd_byte;
        n_frm_ptr  = r_frm_ptr;
        feed_res   = cfd_pkg::FR_MORE;
        unique case (r_phase)
            PH_HUNT_LO: begin
                if (feed_byte == hdr_lo) begin
                    n_fill  = fill_inc;
                    n_crc   = crc_out;
                    n_phase = PH_LEN;
                end else if (feed_byte != hdr_hi) begin
                    n_fill  = '0;
                    n_phase = PH_HUNT_HI;
                end
            end
            PH_LEN: begin
                n_fill = fill_inc;
                n_crc  = crc_out;
                if (feed_byte > 8'(limit_eff)) begin
                    feed_res = cfd_pkg::FR_DROP;
                end else begin
                    n_exp   = feed_byte[LW-1:0];
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_fill = fill_inc;
                n_crc  = crc_out;
                if (r_fill == FW'(cfd_pkg::BODY_OFFSET - 1)) begin
                    n_cmd_byte = feed_byte;
                end
                if (fill_next8 >= 8'(cfd_pkg::BODY_OFFSET) + exp8) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_fill   = fill_inc;
                n_crc_hi = feed_byte;
                if (fill_next8 >= 8'(cfd_pkg::FRAME_OVERHEAD) + exp8) begin
                    feed_res = ({r_crc_hi, feed_byte} == r_crc) ? cfd_pkg::FR_READY
                                                                : cfd_pkg::FR_DROP;
                end
            end
            default: begin
                // first header byte hunt, also taken for unused phase codes
                n_phase = PH_HUNT_HI;
                n_fill  = '0;
            end
        endcase
        if (take_first) begin
            n_frm_ptr = feed_pos;
            n_fill    = FW'(1);
            n_crc     = crc_out;
            n_phase   = PH_HUNT_LO;
        end
        if (feed_res != cfd_pkg::FR_MORE) begin
            n_phase = PH_HUNT_HI;
            n_fill  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= cfd_pkg::HEADER_RESET;
            r_limit <= cfd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cfd_pkg::CFG_HEADER_WORD) begin
                r_hdr <= i_cfg_wdata;
            end else if (i_cfg_idx == cfd_pkg::CFG_PAYLOAD_LIMIT) begin
                r_limit <= i_cfg_wdata[LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT_HI;
            r_fill    <= '0;
            r_exp     <= '0;
            r_crc     <= cfd_pkg::CRC_INIT;
            r_frm_ptr <= '0;
        end else if (feed_en) begin
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_exp     <= n_exp;
            r_crc     <= n_crc;
            r_frm_ptr <= n_frm_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (feed_en) begin
            r_crc_hi   <= n_crc_hi;
            r_cmd_byte <= n_cmd_byte;
        end
        if (i_cmd.rd_replay) begin
            r_feed_pos <= r_rd_ptr;
        end
    end

    // A drop rewinds the read side to the second stored byte of the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_cmd.feed_new) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (feed_en && feed_res == cfd_pkg::FR_DROP) begin
                r_rd_ptr <= r_frm_ptr + 1'b1;
            end else if (i_cmd.feed_new) begin
                r_rd_ptr <= r_wr_ptr + 1'b1;
            end else if (i_cmd.rd_replay) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    assign exp_zero  = (r_exp == '0);
    assign item_last = exp_zero || (LW'(r_k + 1'b1) == r_exp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (feed_en && feed_res == cfd_pkg::FR_READY) begin
                r_k <= '0;
            end else if (i_cmd.load_out) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cmd     <= r_cmd_byte;
            r_out_len     <= r_exp;
            r_out_idx     <= r_k[cfd_pkg::IDX_W-1:0];
            r_out_byte    <= exp_zero ? '0 : ram_rdata;
            r_out_present <= !exp_zero;
            r_out_last    <= item_last;
        end
    end

    assign ram_raddr = i_cmd.rd_emit
                     ? r_frm_ptr + AW'(cfd_pkg::BODY_OFFSET) + AW'(r_k)
                     : r_rd_ptr;

    cfd_ram #(
        .WIDTH (BW),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.feed_new),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_rx_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.replay_pending = (r_rd_ptr != r_wr_ptr);
    assign o_sts.out_free       = !r_out_valid || i_res_ready;
    assign o_sts.last_item      = item_last;
    assign o_sts.feed_res       = feed_res;

    assign o_res_valid      = r_out_valid;
    assign o_command        = r_out_cmd;
    assign o_payload_length = r_out_len;
    assign o_byte_index     = r_out_idx;
    assign o_payload_byte   = r_out_byte;
    assign o_byte_present   = r_out_present;
    assign o_last           = r_out_last;

endmodule

// ===== rtl/core/cfd_ctrl.sv =====
// Deframer sequencer: new bytes, replay of stored bytes and result emission.
`timescale 1ns / 1ps
module cfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  cfd_pkg::t_sts i_sts,
    output cfd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_EMIT,
        S_LOAD
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_rx_ready = !i_sts.replay_pending;
                if (i_sts.replay_pending) begin
                    o_cmd.rd_replay = 1'b1;
                    n_state         = S_FEED;
                end else if (i_rx_valid) begin
                    o_cmd.feed_new = 1'b1;
                    if (i_sts.feed_res == cfd_pkg::FR_READY) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FEED: begin
                o_cmd.feed_replay = 1'b1;
                n_state = (i_sts.feed_res == cfd_pkg::FR_READY) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.rd_emit = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state        = i_sts.last_item ? S_IDLE : S_EMIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
